// ----- rtl/core/tq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tq_pkg
// Shared types and constants of the sorted timer queue with slice deadline.
// ----------------------------------------------------------------------------
package tq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_W    = 16;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_IRQ   = 2'd1;
    localparam logic [1:0] FUNC_POP   = 2'd2;
    localparam logic [1:0] FUNC_SLICE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_HNDL  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [0:0] CFG_SLICE_LEN = 1'd0;
    localparam logic [0:0] CFG_FREQ      = 1'd1;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_POP
    } cmd_op_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [63:0]         now;
        logic [63:0]         delay_seconds;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [63:0]         compare_value;
        logic                compare_enable;
        logic                reschedule;
        logic                start_bottom_half;
        logic                expired_valid;
        logic [HANDLE_W-1:0] expired_handle;
        logic                bottom_half_done;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic [63:0]         expiry;
        logic [HANDLE_W-1:0] handle;
    } cell_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [63:0]         expiry;
        logic [HANDLE_W-1:0] handle;
    } chain_cmd_t;

    typedef struct packed {
        logic        enable;
        logic [63:0] value;
    } arm_t;

endpackage
`default_nettype wire

// ----- rtl/core/tq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tq_cell
// One slot of the sorted timer chain: keeps, takes the new timer, or shifts.
// ----------------------------------------------------------------------------
module tq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tq_pkg::chain_cmd_t  cmd,
    input  tq_pkg::cell_t       prev_cell,
    input  logic                prev_le,
    input  tq_pkg::cell_t       next_cell,
    output tq_pkg::cell_t       slot,
    output logic                le
);
    import tq_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;

    // Equal expiries stay ahead of the new timer to keep arrival order
    assign le   = cell_reg.valid && (cell_reg.expiry <= cmd.expiry);
    assign slot = cell_reg;

    always_comb
    begin
        cell_next = cell_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (!le)
                begin
                    if (prev_le)
                    begin
                        cell_next.valid  = 1'b1;
                        cell_next.expiry = cmd.expiry;
                        cell_next.handle = cmd.handle;
                    end
                    else
                    begin
                        cell_next = prev_cell;
                    end
                end
            end
            CMD_POP:
            begin
                cell_next = next_cell;
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/tq_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tq_chain
// Row of timer cells kept sorted by expiry; head sits in cell zero.
// ----------------------------------------------------------------------------
module tq_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  tq_pkg::chain_cmd_t  cmd,
    output tq_pkg::cell_t       head,
    output logic                full
);
    import tq_pkg::*;

    cell_t cells [QUEUE_DEPTH];
    logic  les   [QUEUE_DEPTH];
    cell_t empty_cell;

    assign empty_cell = '{valid: 1'b0, expiry: 64'd0, handle: '0};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_t prev_c;
        logic  prev_l;
        cell_t next_c;

        if (i == 0)
        begin : g_first
            assign prev_c = empty_cell;
            assign prev_l = 1'b1;
        end
        else
        begin : g_mid
            assign prev_c = cells[i-1];
            assign prev_l = les[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_c = empty_cell;
        end
        else
        begin : g_inner
            assign next_c = cells[i+1];
        end

        tq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .prev_cell (prev_c),
            .prev_le   (prev_l),
            .next_cell (next_c),
            .slot      (cells[i]),
            .le        (les[i])
        );
    end

    assign head = cells[0];
    assign full = cells[QUEUE_DEPTH-1].valid;

endmodule
`default_nettype wire

// ----- rtl/core/timer_queue_with_slice_deadline.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timer_queue_with_slice_deadline
// One compare timer shared by a scheduling slice and a sorted timer queue.
// ----------------------------------------------------------------------------
// Interrupt, pop and slice reset are handled in S_EXEC and answered from
// S_RESP; an accepted add steps through the 64x32 multiply done
// as two 32x32 partial products, a 96-bit sum, the overflow check, the
// insert into the cell chain and, when needed, the compare reprogramming.
// One item at a time; the next transfer is taken once the
// result is in the output register. Reset clears queue occupancy, pending
// mark, slice deadline, compare state and both registers.
module timer_queue_with_slice_deadline (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tq_pkg::req_t  req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tq_pkg::rsp_t  rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [0:0]    cfg_index,
    input  logic [63:0]   cfg_data
);
    import tq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_CHECK,
        S_INSERT,
        S_PROG,
        S_RESP
    } state_t;

    state_t      state_reg;
    req_t        item_reg;
    rsp_t        res_reg;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;
    logic [63:0] slice_len_reg;
    logic [31:0] freq_reg;
    logic [63:0] slice_dead_reg;
    logic        pending_reg;
    arm_t        arm_reg;
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [95:0] prod_reg;
    logic [63:0] expiry_reg;

    cell_t       head;
    logic        full;
    chain_cmd_t  cmd;
    logic        due;
    logic [96:0] sum;
    logic [63:0] dead_irq;
    logic        resched;
    logic        start_bh;

    function automatic arm_t program_cmp(
        input logic [63:0] slen,
        input logic [63:0] sdead,
        input cell_t       hd,
        input logic        pend,
        input arm_t        cur
    );
        arm_t        r;
        logic [63:0] dl;
        logic        on;
        dl = sdead;
        on = (slen != 64'd0);
        if (hd.valid && !pend && (!on || hd.expiry < dl))
        begin
            dl = hd.expiry;
            on = 1'b1;
        end
        r.enable = on;
        r.value  = on ? dl : cur.value;
        return r;
    endfunction

    tq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .full  (full)
    );

    assign due      = head.valid && (head.expiry <= item_reg.now);
    assign sum      = {33'd0, item_reg.now} + {1'b0, prod_reg};
    assign resched  = (slice_len_reg != 64'd0) && (item_reg.now >= slice_dead_reg);
    assign dead_irq = resched ? item_reg.now + slice_len_reg : slice_dead_reg;
    assign start_bh = due && !pending_reg;

    always_comb
    begin
        cmd.op     = CMD_NONE;
        cmd.expiry = expiry_reg;
        cmd.handle = item_reg.handle;
        if (state_reg == S_INSERT)
        begin
            cmd.op = CMD_INSERT;
        end
        else if (state_reg == S_EXEC && item_reg.func == FUNC_POP && due)
        begin
            cmd.op = CMD_POP;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            slice_len_reg  <= 64'd0;
            freq_reg       <= 32'd0;
            slice_dead_reg <= 64'd0;
            pending_reg    <= 1'b0;
            arm_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SLICE_LEN: slice_len_reg <= cfg_data;
                    CFG_FREQ:      freq_reg      <= cfg_data[31:0];
                    default:       freq_reg      <= freq_reg;
                endcase
            end

            // drop the result once taken, unless a new one replaces it
            if (rsp_valid_reg && !rsp_stall && state_reg != S_RESP)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg  <= req;
                        res_reg   <= '0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (item_reg.func)
                        FUNC_ADD:
                        begin
                            if (item_reg.handle == '0)
                            begin
                                res_reg.status <= ST_NO_HNDL;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_MUL_LO;
                            end
                        end
                        FUNC_IRQ:
                        begin
                            slice_dead_reg            <= dead_irq;
                            pending_reg               <= pending_reg || due;
                            res_reg.reschedule        <= resched;
                            res_reg.start_bottom_half <= start_bh;
                            arm_reg   <= program_cmp(slice_len_reg, dead_irq, head,
                                                     pending_reg || due, arm_reg);
                            state_reg <= S_RESP;
                        end
                        FUNC_POP:
                        begin
                            if (due)
                            begin
                                res_reg.expired_valid  <= 1'b1;
                                res_reg.expired_handle <= head.handle;
                            end
                            else
                            begin
                                pending_reg              <= 1'b0;
                                res_reg.bottom_half_done <= 1'b1;
                                arm_reg <= program_cmp(slice_len_reg, slice_dead_reg,
                                                       head, 1'b0, arm_reg);
                            end
                            state_reg <= S_RESP;
                        end
                        default:
                        begin
                            if (slice_len_reg != 64'd0)
                            begin
                                slice_dead_reg <= item_reg.now + slice_len_reg;
                                arm_reg <= program_cmp(slice_len_reg,
                                                       item_reg.now + slice_len_reg,
                                                       head, pending_reg, arm_reg);
                            end
                            else
                            begin
                                arm_reg <= program_cmp(slice_len_reg, slice_dead_reg,
                                                       head, pending_reg, arm_reg);
                            end
                            state_reg <= S_RESP;
                        end
                    endcase
                end
                S_MUL_LO:
                begin
                    plo_reg   <= item_reg.delay_seconds[31:0] * freq_reg;
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    phi_reg   <= item_reg.delay_seconds[63:32] * freq_reg;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    prod_reg  <= {phi_reg, 32'd0} + {32'd0, plo_reg};
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    // carry past bit 63 means the expiry does not fit
                    if (sum[96:64] != 33'd0)
                    begin
                        res_reg.status <= ST_OVERFLOW;
                        state_reg      <= S_RESP;
                    end
                    else if (full)
                    begin
                        res_reg.status <= ST_FULL;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        expiry_reg <= sum[63:0];
                        state_reg  <= S_INSERT;
                    end
                end
                S_INSERT:
                begin
                    res_reg.status <= ST_OK;
                    // reprogram only when the new timer lands at the head
                    if (!(head.valid && head.expiry <= expiry_reg) && !pending_reg)
                    begin
                        state_reg <= S_PROG;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_PROG:
                begin
                    arm_reg   <= program_cmp(slice_len_reg, slice_dead_reg, head,
                                             pending_reg, arm_reg);
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg <= '{status:            res_reg.status,
                                     compare_value:     arm_reg.value,
                                     compare_enable:    arm_reg.enable,
                                     reschedule:        res_reg.reschedule,
                                     start_bottom_half: res_reg.start_bottom_half,
                                     expired_valid:     res_reg.expired_valid,
                                     expired_handle:    res_reg.expired_handle,
                                     bottom_half_done:  res_reg.bottom_half_done};
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_stall_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("input taken while an item is in flight");

    a_reject_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (!rsp.reschedule && !rsp.expired_valid
            && !rsp.start_bottom_half && !rsp.bottom_half_done))
        else $error("rejected add carries event flags");

    a_pop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.expired_valid) |-> !rsp.bottom_half_done)
        else $error("pop both delivered a timer and finished");

    a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.expired_valid) |-> (rsp.expired_handle != '0))
        else $error("expired timer carries a zero handle");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timer queue with slice deadline: a queued
// driver feeds adds, interrupts, pops and slice restarts under random idling
// and back-pressure; a monitor checks each result against a local predictor.
// ----------------------------------------------------------------------------
module tb;
    import tq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;

    timer_queue_with_slice_deadline DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [63:0]         q_expiry [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] q_handle [QUEUE_DEPTH];
    int                  q_count;
    logic                bh_pending;
    logic [63:0]         slice_end;
    logic [63:0]         arm_value;
    logic                arm_on;
    logic [63:0]         slice_len;
    logic [31:0]         freq;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    int   errors;
    int   n_sent;
    int   n_checked;
    int   quiet_cycles;
    int   n_add_ok;
    int   n_add_rej;
    int   n_due;
    logic all_queued;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void rearm();
        logic [63:0] dl;
        logic        on;
        dl = slice_end;
        on = slice_len != 0;
        if (q_count > 0 && !bh_pending && (!on || q_expiry[0] < dl))
        begin
            dl = q_expiry[0];
            on = 1'b1;
        end
        if (on)
        begin
            arm_value = dl;
            arm_on = 1'b1;
        end
        else
            arm_on = 1'b0;
    endfunction

    function automatic rsp_t predict_timer_result(req_t r);
        rsp_t        o;
        logic [63:0] expiry;
        int          pos;
        o = '0;
        case (r.func)
            FUNC_ADD:
            begin
                if (r.handle == 0)
                    o.status = ST_NO_HNDL;
                else if (freq != 0 && r.delay_seconds > (64'hFFFF_FFFF_FFFF_FFFF - r.now) / freq)
                    o.status = ST_OVERFLOW;
                else if (q_count >= QUEUE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    o.status = ST_OK;
                    expiry = r.now + r.delay_seconds * {32'd0, freq};
                    pos = 0;
                    while (pos < q_count && q_expiry[pos] <= expiry)
                        pos++;
                    for (int k = q_count; k > pos; k--)
                    begin
                        q_expiry[k] = q_expiry[k-1];
                        q_handle[k] = q_handle[k-1];
                    end
                    q_expiry[pos] = expiry;
                    q_handle[pos] = r.handle;
                    q_count++;
                    if (pos == 0 && !bh_pending)
                        rearm();
                end
            end
            FUNC_IRQ:
            begin
                arm_on = 1'b0;
                if (slice_len != 0 && r.now >= slice_end)
                begin
                    o.reschedule = 1'b1;
                    slice_end = r.now + slice_len;
                end
                if (q_count > 0 && q_expiry[0] <= r.now && !bh_pending)
                begin
                    bh_pending = 1'b1;
                    o.start_bottom_half = 1'b1;
                end
                rearm();
            end
            FUNC_POP:
            begin
                if (q_count == 0 || q_expiry[0] > r.now)
                begin
                    bh_pending = 1'b0;
                    rearm();
                    o.bottom_half_done = 1'b1;
                end
                else
                begin
                    o.expired_valid = 1'b1;
                    o.expired_handle = q_handle[0];
                    for (int k = 1; k < q_count; k++)
                    begin
                        q_expiry[k-1] = q_expiry[k];
                        q_handle[k-1] = q_handle[k];
                    end
                    q_count--;
                end
            end
            default:
            begin
                if (slice_len != 0)
                    slice_end = r.now + slice_len;
                rearm();
            end
        endcase
        o.compare_value = arm_value;
        o.compare_enable = arm_on;
        return o;
    endfunction

    // driver: next item goes out only after the current one transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // predict on transfer
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsps.push_back(predict_timer_result(req));
            n_sent++;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_off > 0)
        begin
            rsp_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            rsp_stall <= $urandom_range(99) < recv_stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_checked++;
            if (expected_rsps.size() == 0)
            begin
                $error("result with no transfer waiting");
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (e.expired_valid)
                    n_due++;
                if (rsp.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.compare_value !== e.compare_value)
                begin
                    $error("compare_value exp %0h got %0h", e.compare_value, rsp.compare_value);
                    errors++;
                end
                if (rsp.compare_enable !== e.compare_enable)
                begin
                    $error("compare_enable exp %0b got %0b", e.compare_enable,
                           rsp.compare_enable);
                    errors++;
                end
                if (rsp.reschedule !== e.reschedule)
                begin
                    $error("reschedule exp %0b got %0b", e.reschedule, rsp.reschedule);
                    errors++;
                end
                if (rsp.start_bottom_half !== e.start_bottom_half)
                begin
                    $error("start_bottom_half exp %0b got %0b", e.start_bottom_half,
                           rsp.start_bottom_half);
                    errors++;
                end
                if (rsp.expired_valid !== e.expired_valid)
                begin
                    $error("expired_valid exp %0b got %0b", e.expired_valid,
                           rsp.expired_valid);
                    errors++;
                end
                if (rsp.expired_handle !== e.expired_handle)
                begin
                    $error("expired_handle exp %0h got %0h", e.expired_handle,
                           rsp.expired_handle);
                    errors++;
                end
                if (rsp.bottom_half_done !== e.bottom_half_done)
                begin
                    $error("bottom_half_done exp %0b got %0b", e.bottom_half_done,
                           rsp.bottom_half_done);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (!all_queued || pending_reqs.size() > 0 || expected_rsps.size() > 0)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("timeout with %0d results outstanding", expected_rsps.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLICE_LEN)
            slice_len = val;
        else
            freq = val[31:0];
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [1:0] f, logic [63:0] t, logic [63:0] d,
                                      logic [HANDLE_W-1:0] h);
        req_t r;
        r.func = f;
        r.now = t;
        r.delay_seconds = d;
        r.handle = h;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly timer life cycles on a moving clock, with some raw noise
    task automatic queue_random(input int n);
        logic [63:0] t;
        int          pick;
        t = {32'd0, $urandom()};
        for (int i = 0; i < n; i++)
        begin
            t = t + $urandom_range(40);
            pick = $urandom_range(99);
            if (pick < 10)
                pending_reqs.push_back(make_req(2'($urandom_range(3)), rand64(), rand64(),
                                                16'($urandom())));
            else if (pick < 45)
                pending_reqs.push_back(make_req(FUNC_ADD, t, $urandom_range(12),
                                       ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom())));
            else if (pick < 65)
                pending_reqs.push_back(make_req(FUNC_IRQ, t, rand64(), 16'($urandom())));
            else if (pick < 92)
                pending_reqs.push_back(make_req(FUNC_POP, t, rand64(), 16'($urandom())));
            else
                pending_reqs.push_back(make_req(FUNC_SLICE, t, rand64(), 16'($urandom())));
        end
    endtask

    initial
    begin
        logic [63:0] max64;
        int          idle_sets[4][2];
        max64 = '1;
        idle_sets = '{'{0, 0}, '{52, 0}, '{0, 52}, '{35, 35}};
        errors = 0; n_sent = 0; n_checked = 0; quiet_cycles = 0; hold_off = 0;
        n_add_ok = 0; n_add_rej = 0; n_due = 0;
        all_queued = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        q_count = 0; bh_pending = 0; slice_end = 0; arm_value = 0; arm_on = 0;
        slice_len = 0; freq = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero frequency, no slice
        pending_reqs.push_back(make_req(FUNC_POP, 64'd5, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd100, max64, 16'd0));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd100, max64, 16'hFFFF));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd100, 64'd3, 16'h0001));
        pending_reqs.push_back(make_req(FUNC_IRQ, 64'd100, 0, 0));
        pending_reqs.push_back(make_req(FUNC_POP, 64'd100, 0, 0));
        pending_reqs.push_back(make_req(FUNC_POP, 64'd100, 0, 0));
        pending_reqs.push_back(make_req(FUNC_SLICE, max64, 0, 0));
        drain();

        write_reg(CFG_FREQ, 64'hFFFF_FFFF);
        write_reg(CFG_SLICE_LEN, max64);
        pending_reqs.push_back(make_req(FUNC_SLICE, max64, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd0, max64, 16'h5));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd0, 64'hFFFF_FFFF, 16'h6));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd0, 64'h1_0000_0001, 16'h7));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd10, 64'd0, 16'h8));
        pending_reqs.push_back(make_req(FUNC_ADD, 64'd10, 64'd0, 16'h9));
        pending_reqs.push_back(make_req(FUNC_IRQ, max64, 0, 0));
        pending_reqs.push_back(make_req(FUNC_POP, max64, 0, 0));
        pending_reqs.push_back(make_req(FUNC_POP, max64, 0, 0));
        pending_reqs.push_back(make_req(FUNC_POP, max64, 0, 0));
        pending_reqs.push_back(make_req(FUNC_POP, max64, 0, 0));
        // fill past capacity
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            pending_reqs.push_back(make_req(FUNC_ADD, 64'd50, 64'(i % 3), 16'(i + 1)));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin write_reg(CFG_SLICE_LEN, 64'd0);   write_reg(CFG_FREQ, 64'd1); end
                1: begin write_reg(CFG_SLICE_LEN, 64'd25);  write_reg(CFG_FREQ, 64'd4); end
                2: begin write_reg(CFG_SLICE_LEN, 64'd120); write_reg(CFG_FREQ, 64'd0); end
                default:
                begin
                    write_reg(CFG_SLICE_LEN, 64'($urandom_range(300)));
                    write_reg(CFG_FREQ, 64'($urandom_range(20)));
                end
            endcase
            send_idle_pct = idle_sets[ph % 4][0];
            recv_stall_pct = idle_sets[ph % 4][1];
            if (ph == 3)
                hold_off = 400;
            queue_random(140);
            drain();
        end
        all_queued = 1'b1;
        repeat (20) @(posedge clk);
        $display("%0d items checked over 10 register settings with idling and stall phases",
                 n_checked);
        $display("%0d timers delivered by pops", n_due);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
